// File: sv/obex_header_scanner_assert.svh
// Assertion macros for the OBEX header scanner checker.
// Each macro expects signals named clk and arst_n in the scope that uses it.
`ifndef OBEX_HEADER_SCANNER_ASSERT_SVH
`define OBEX_HEADER_SCANNER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define OHS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ohs assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define OHS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ohs assertion failed");

`endif

// File: sv/ohs_pkg.sv
// Package for the OBEX header scanner: payload structs, byte kinds and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ohs_pkg;

	// Byte kinds reported per result
	localparam logic [2:0] KIND_IDENT   = 3'd0;
	localparam logic [2:0] KIND_LENGTH  = 3'd1;
	localparam logic [2:0] KIND_CONTENT = 3'd2;
	localparam logic [2:0] KIND_FOUND   = 3'd3;
	localparam logic [2:0] KIND_IGNORED = 3'd4;

	// Header classes (identifier bits 7..6)
	localparam logic [1:0] CLS_ONE_BYTE  = 2'd2;
	localparam logic [1:0] CLS_FOUR_BYTE = 2'd3;

	// Configuration register indexes and reset values
	localparam logic CFG_BODY_ID     = 1'b0;
	localparam logic CFG_END_BODY_ID = 1'b1;
	localparam logic [7:0] BODY_ID_RST     = 8'h48;
	localparam logic [7:0] END_BODY_ID_RST = 8'h49;

	// Length prefix counts itself and the identifier
	localparam logic [15:0] LEN_OVERHEAD = 16'd3;
	localparam logic [15:0] SIZE_ONE     = 16'd1;
	localparam logic [15:0] SIZE_FOUR    = 16'd4;
	localparam logic [15:0] POS_MAX      = 16'hFFFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} ohs_in_t;

	typedef struct packed {
		logic [2:0]  byte_kind;
		logic [7:0]  header_ident;
		logic [1:0]  header_class;
		logic [15:0] byte_offset;
		logic [15:0] content_size;
		logic [7:0]  content_value;
		logic        header_done;
		logic        not_found;
		logic        malformed;
	} ohs_out_t;

endpackage

`default_nettype wire

// File: sv/obex_header_scanner.sv
// Top level of the OBEX header scanner: input register, scan core, result register.
// Depends on ohs_pkg and ohs_scan_core.
`timescale 1ns / 1ps
`default_nettype none

// The scanner takes one header-region byte per cycle while in_stall is low and
// returns one result per byte, in order, via the input and result registers.
// Throughput is one byte per clock while the output is not stalled: the core
// classifies the input register's byte combinationally and its state updates
// as the result is registered. A stall on the output holds the result
// register; the input register still takes a byte while the result waits, and
// in_stall rises only when both registers are full. body_id and end_body_id
// reset to 0x48 and 0x49 and should be written only while no byte is in flight.
module obex_header_scanner (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire ohs_pkg::ohs_in_t in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output ohs_pkg::ohs_out_t  out_data,
	input  wire logic          cfg_we,
	input  wire logic          cfg_index,
	input  wire logic [7:0]    cfg_wdata
);
	import ohs_pkg::*;

	ohs_in_t    item_s1;
	logic       valid_s1;
	ohs_out_t   res_s2;
	logic       valid_s2;
	ohs_out_t   res_comb;
	logic       s2_open, advance;
	logic [7:0] body_id_q, end_body_id_q;

	assign s2_open  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_open;
	assign in_stall = valid_s1 && !s2_open;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_id_q     <= BODY_ID_RST;
			end_body_id_q <= END_BODY_ID_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BODY_ID:     body_id_q <= cfg_wdata;
				CFG_END_BODY_ID: end_body_id_q <= cfg_wdata;
				default:         body_id_q <= body_id_q;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	ohs_scan_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.body_id     (body_id_q),
		.end_body_id (end_body_id_q),
		.result      (res_comb)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_open) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

`default_nettype wire

// File: sv/ohs_scan_core.sv
// Scan state and per-byte classification for the OBEX header scanner.
// Depends on ohs_pkg. The result is combinational; state advances on step.
`timescale 1ns / 1ps
`default_nettype none

module ohs_scan_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire ohs_pkg::ohs_in_t item,
	input  wire logic [7:0]      body_id,
	input  wire logic [7:0]      end_body_id,
	output ohs_pkg::ohs_out_t    result
);
	import ohs_pkg::*;

	localparam logic [2:0] PH_IDENT   = 3'd0;
	localparam logic [2:0] PH_LENHI   = 3'd1;
	localparam logic [2:0] PH_LENLO   = 3'd2;
	localparam logic [2:0] PH_CONTENT = 3'd3;
	localparam logic [2:0] PH_FOUND   = 3'd4;
	localparam logic [2:0] PH_BAD     = 3'd5;

	logic [2:0]  phase_q, phase_cur, phase_n;
	logic [15:0] pos_q, pos_cur, pos_n;
	logic [7:0]  ident_q, ident_n;
	logic [7:0]  len_hi_q, len_hi_n;
	logic [15:0] left_q, left_n, left_dec;
	logic [15:0] size_q, size_n;
	logic [15:0] len_full, csize;
	logic [2:0]  kind;
	logic        done, bad, incomplete, found;
	logic [7:0]  d;

	assign d = item.data_byte;
	assign len_full = {len_hi_q, d};
	assign left_dec = (left_q != 16'd0) ? (left_q - 16'd1) : left_q;

	// Next-state and result for the byte in the input register
	always_comb begin
		phase_cur = item.first_byte ? PH_IDENT : phase_q;
		pos_cur = item.first_byte ? 16'd0 : pos_q;
		pos_n = (pos_cur != POS_MAX) ? (pos_cur + 16'd1) : pos_cur;
		phase_n = phase_cur;
		ident_n = ident_q;
		len_hi_n = len_hi_q;
		left_n = left_q;
		size_n = size_q;
		kind = KIND_IDENT;
		csize = 16'd0;
		done = 1'b0;
		bad = 1'b0;
		incomplete = 1'b0;
		found = 1'b0;
		unique case (phase_cur)
			PH_LENHI: begin
				kind = KIND_LENGTH;
				len_hi_n = d;
				phase_n = PH_LENLO;
				incomplete = 1'b1;
			end
			PH_LENLO: begin
				kind = KIND_LENGTH;
				if (len_full < LEN_OVERHEAD) begin
					bad = 1'b1;
					size_n = 16'd0;
					phase_n = PH_BAD;
				end else begin
					size_n = len_full - LEN_OVERHEAD;
					csize = size_n;
					if (size_n == 16'd0) begin
						done = 1'b1;
						phase_n = PH_IDENT;
					end else begin
						left_n = size_n;
						phase_n = PH_CONTENT;
						incomplete = 1'b1;
					end
				end
			end
			PH_CONTENT: begin
				kind = KIND_CONTENT;
				csize = size_q;
				left_n = left_dec;
				if (left_dec == 16'd0) begin
					done = 1'b1;
					phase_n = PH_IDENT;
				end else begin
					incomplete = 1'b1;
				end
			end
			PH_FOUND: begin
				kind = KIND_IGNORED;
				found = 1'b1;
			end
			PH_BAD: begin
				kind = KIND_IGNORED;
				bad = 1'b1;
			end
			default: begin
				ident_n = d;
				if (d == body_id || d == end_body_id) begin
					kind = KIND_FOUND;
					found = 1'b1;
					size_n = 16'd0;
					phase_n = PH_FOUND;
				end else begin
					kind = KIND_IDENT;
					incomplete = 1'b1;
					if (d[7:6] == CLS_ONE_BYTE || d[7:6] == CLS_FOUR_BYTE) begin
						size_n = (d[7:6] == CLS_ONE_BYTE) ? SIZE_ONE : SIZE_FOUR;
						left_n = size_n;
						csize = size_n;
						phase_n = PH_CONTENT;
					end else begin
						size_n = 16'd0;
						phase_n = PH_LENHI;
					end
				end
			end
		endcase
		// an unfinished header at region end is malformed
		if (item.last_byte && incomplete) begin
			bad = 1'b1;
		end
		// region end restarts the scan
		if (item.last_byte) begin
			phase_n = PH_IDENT;
			pos_n = 16'd0;
		end
	end

	// Result fields
	always_comb begin
		result.byte_kind     = kind;
		result.header_ident  = ident_n;
		result.header_class  = ident_n[7:6];
		result.byte_offset   = pos_cur;
		result.content_size  = csize;
		result.content_value = d;
		result.header_done   = done;
		result.not_found     = item.last_byte && !found;
		result.malformed     = bad;
	end

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDENT;
			pos_q    <= 16'd0;
			ident_q  <= 8'd0;
			len_hi_q <= 8'd0;
			left_q   <= 16'd0;
			size_q   <= 16'd0;
		end else if (step) begin
			phase_q  <= phase_n;
			pos_q    <= pos_n;
			ident_q  <= ident_n;
			len_hi_q <= len_hi_n;
			left_q   <= left_n;
			size_q   <= size_n;
		end
	end

endmodule

`default_nettype wire

// File: sv/ohs_checker.sv
// Port-level checker for the OBEX header scanner, bound to the top level.
// Depends on ohs_pkg and obex_header_scanner_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "obex_header_scanner_assert.svh"

module ohs_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_stall,
	input  wire ohs_pkg::ohs_in_t in_data,
	input  wire logic          out_valid,
	input  wire logic          out_stall,
	input  wire ohs_pkg::ohs_out_t out_data
);
	import ohs_pkg::*;

	logic in_req;
	logic tail_kind, tail_clean;
	assign in_req = in_valid && in_data.first_byte;
	assign tail_kind = out_data.byte_kind == KIND_FOUND || out_data.byte_kind == KIND_IGNORED;
	assign tail_clean = !out_data.header_done && out_data.content_size == 16'd0;

	// a stalled result request holds
	`OHS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
	// input backs up only behind a stalled, full output
	`OHS_ASSERT_IMP(a_stall_cause, in_stall || (in_req && 1'b0), out_valid && out_stall)
	// class is always the top bits of the reported identifier
	`OHS_ASSERT_IMP(a_class, out_valid, out_data.header_class == out_data.header_ident[7:6])
	// a found body or an ignored byte never completes a header or carries a size
	`OHS_ASSERT_IMP(a_found, out_valid && tail_kind, tail_clean)

endmodule

bind obex_header_scanner ohs_checker u_ohs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
